// ----- rtl/ktbl_pkg.sv -----
package ktbl_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int RATE_FRAC_DEF = 8;

    localparam int KEY_W     = 64;
    localparam int RATE_W    = 28;
    localparam int BURST_W   = 16;
    localparam int TIME_W    = 48;
    localparam int STATUS_W  = 3;
    localparam int INDEX_W   = 4;
    localparam int MILLION_W = 20;

    localparam logic [MILLION_W-1:0] MILLION = 20'd1000000;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_CHECK = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_UNKNOWN = 3'd1,
        ST_LIMITED = 3'd2,
        ST_DUP     = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [KEY_W-1:0]   key_value;
        logic [RATE_W-1:0]  rate_q8;
        logic [BURST_W-1:0] burst_cap;
        logic [TIME_W-1:0]  now_time;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [INDEX_W-1:0] entry_index;
        logic [BURST_W-1:0] tokens_left;
    } out_item_t;

    typedef struct packed {
        logic act;
        logic hit;
    } link_t;

    typedef struct packed {
        logic add;
        logic upd;
    } wr_ctl_t;

    typedef struct packed {
        logic done;
        logic limited;
        logic upd;
    } rf_stat_t;

endpackage

// ----- rtl/ktbl_cell.sv -----
module ktbl_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 4,
    parameter int LEVEL_W  = 44
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            occupied,
    input  logic [ktbl_pkg::KEY_W-1:0]      srch_key,
    input  ktbl_pkg::link_t                 link_in,
    input  logic [IDX_W-1:0]                idx_in,
    input  logic [ktbl_pkg::RATE_W-1:0]     rate_in,
    input  logic [ktbl_pkg::BURST_W-1:0]    burst_in,
    input  logic [LEVEL_W-1:0]              level_in,
    input  logic [ktbl_pkg::TIME_W-1:0]     last_in,
    output ktbl_pkg::link_t                 link_out,
    output logic [IDX_W-1:0]                idx_out,
    output logic [ktbl_pkg::RATE_W-1:0]     rate_out,
    output logic [ktbl_pkg::BURST_W-1:0]    burst_out,
    output logic [LEVEL_W-1:0]              level_out,
    output logic [ktbl_pkg::TIME_W-1:0]     last_out,
    input  ktbl_pkg::wr_ctl_t               wr_ctl,
    input  logic [IDX_W-1:0]                wr_idx,
    input  logic [ktbl_pkg::KEY_W-1:0]      wr_key,
    input  logic [ktbl_pkg::RATE_W-1:0]     wr_rate,
    input  logic [ktbl_pkg::BURST_W-1:0]    wr_burst,
    input  logic [LEVEL_W-1:0]              wr_level,
    input  logic [ktbl_pkg::TIME_W-1:0]     wr_last
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [ktbl_pkg::KEY_W-1:0]   key_reg;
    logic [ktbl_pkg::RATE_W-1:0]  rate_reg;
    logic [ktbl_pkg::BURST_W-1:0] burst_reg;
    logic [LEVEL_W-1:0]           level_reg;
    logic [ktbl_pkg::TIME_W-1:0]  last_reg;

    ktbl_pkg::link_t              link_reg, link_next;
    logic [IDX_W-1:0]             idx_out_reg;
    logic [ktbl_pkg::RATE_W-1:0]  rate_out_reg;
    logic [ktbl_pkg::BURST_W-1:0] burst_out_reg;
    logic [LEVEL_W-1:0]           level_out_reg;
    logic [ktbl_pkg::TIME_W-1:0]  last_out_reg;

    logic match;
    logic sel;

    assign match = link_in.act && !link_in.hit && occupied && (key_reg == srch_key);
    assign sel   = (wr_idx == MY_IDX);

    always_comb begin
        link_next.act = link_in.act;
        link_next.hit = link_in.hit | match;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg <= '0;
        end else begin
            link_reg <= link_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (match) begin
            idx_out_reg   <= MY_IDX;
            rate_out_reg  <= rate_reg;
            burst_out_reg <= burst_reg;
            level_out_reg <= level_reg;
            last_out_reg  <= last_reg;
        end else begin
            idx_out_reg   <= idx_in;
            rate_out_reg  <= rate_in;
            burst_out_reg <= burst_in;
            level_out_reg <= level_in;
            last_out_reg  <= last_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_ctl.add && sel) begin
            key_reg   <= wr_key;
            rate_reg  <= wr_rate;
            burst_reg <= wr_burst;
            level_reg <= wr_level;
            last_reg  <= wr_last;
        end else if (wr_ctl.upd && sel) begin
            level_reg <= wr_level;
            last_reg  <= wr_last;
        end
    end

    assign link_out  = link_reg;
    assign idx_out   = idx_out_reg;
    assign rate_out  = rate_out_reg;
    assign burst_out = burst_out_reg;
    assign level_out = level_out_reg;
    assign last_out  = last_out_reg;

endmodule

// ----- rtl/ktbl_refill.sv -----
module ktbl_refill #(
    parameter int RATE_FRAC_BITS = 8,
    parameter int LEVEL_W        = 44
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ktbl_pkg::RATE_W-1:0]  rate,
    input  logic [ktbl_pkg::BURST_W-1:0] burst,
    input  logic [LEVEL_W-1:0]           level,
    input  logic [ktbl_pkg::TIME_W-1:0]  last,
    input  logic [ktbl_pkg::TIME_W-1:0]  now,
    output ktbl_pkg::rf_stat_t           stat,
    output logic [LEVEL_W-1:0]           level_out,
    output logic [ktbl_pkg::BURST_W-1:0] tokens
);

    localparam int TIME_W  = ktbl_pkg::TIME_W;
    localparam int RATE_W  = ktbl_pkg::RATE_W;
    localparam int BURST_W = ktbl_pkg::BURST_W;
    localparam int Q_W     = BURST_W + ktbl_pkg::MILLION_W;
    localparam int DT_W    = (LEVEL_W < TIME_W) ? LEVEL_W : TIME_W;
    localparam int H       = (DT_W + 1) / 2;
    localparam int P_W     = DT_W + RATE_W;
    localparam int PLO_W   = H + RATE_W;
    localparam int PHI_W   = DT_W - H + RATE_W;

    // whole tokens = floor((units >> 6) / 15625) = floor(y * RECIP / 2^44) for y < 2^30
    localparam int DIV_PRE  = 6;
    localparam int Y_W      = LEVEL_W - RATE_FRAC_BITS - DIV_PRE;
    localparam int RECIP_W  = 31;
    localparam int RECIP_SH = 44;
    localparam int RP_W     = Y_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP     = 31'd1125899907;
    localparam logic [LEVEL_W-1:0] TOKEN_ONE = LEVEL_W'(ktbl_pkg::MILLION) << RATE_FRAC_BITS;

    typedef enum logic [7:0] {
        R_IDLE = 8'b0000_0001,
        R_PREP = 8'b0000_0010,
        R_MLO  = 8'b0000_0100,
        R_MHI  = 8'b0000_1000,
        R_SUM  = 8'b0001_0000,
        R_FILL = 8'b0010_0000,
        R_TAKE = 8'b0100_0000,
        R_DIV  = 8'b1000_0000
    } rstate_t;

    rstate_t              state_reg, state_next;
    logic                 done_reg, done_next;
    logic                 mode_reg;
    logic                 sat_reg;
    logic [DT_W-1:0]      dt_reg;
    logic [LEVEL_W-1:0]   cap_reg;
    logic [LEVEL_W-1:0]   lvl_reg;
    logic [LEVEL_W-1:0]   room_reg;
    logic [PLO_W-1:0]     prod_lo_reg;
    logic [PHI_W-1:0]     prod_hi_reg;
    logic [P_W-1:0]       prod_reg;
    logic [LEVEL_W-1:0]   fill_reg;
    logic [LEVEL_W-1:0]   level_out_reg;
    logic                 limited_reg;
    logic [Y_W-1:0]       y_reg;
    logic [RP_W-1:0]      recip_reg;

    logic [TIME_W:0]      diff;
    logic [TIME_W-1:0]    diff_pos;
    logic [Q_W-1:0]       cap_units;
    logic [LEVEL_W-1:0]   take_level;
    logic                 take_lim;

    assign diff      = {1'b0, now} - {1'b0, last};
    assign diff_pos  = diff[TIME_W] ? '0 : diff[TIME_W-1:0];
    assign cap_units = Q_W'(burst) * Q_W'(ktbl_pkg::MILLION);

    always_comb begin
        if (!mode_reg) begin
            take_level = level;
            take_lim   = 1'b0;
        end else if (fill_reg < TOKEN_ONE) begin
            take_level = fill_reg;
            take_lim   = 1'b1;
        end else begin
            take_level = fill_reg - TOKEN_ONE;
            take_lim   = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            R_IDLE: if (start) state_next = R_PREP;
            R_PREP: state_next = R_MLO;
            R_MLO:  state_next = R_MHI;
            R_MHI:  state_next = R_SUM;
            R_SUM:  state_next = R_FILL;
            R_FILL: state_next = R_TAKE;
            R_TAKE: state_next = R_DIV;
            R_DIV: begin
                state_next = R_IDLE;
                done_next  = 1'b1;
            end
            default: state_next = R_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            R_PREP: begin
                mode_reg <= (rate != '0) && (burst != '0);
                sat_reg  <= ((diff_pos >> DT_W) != '0);
                dt_reg   <= diff_pos[DT_W-1:0];
                cap_reg  <= LEVEL_W'(cap_units) << RATE_FRAC_BITS;
            end
            R_MLO: begin
                prod_lo_reg <= PLO_W'(dt_reg[H-1:0]) * PLO_W'(rate);
                lvl_reg     <= (level > cap_reg) ? cap_reg : level;
            end
            R_MHI: begin
                prod_hi_reg <= PHI_W'(dt_reg[DT_W-1:H]) * PHI_W'(rate);
                room_reg    <= cap_reg - lvl_reg;
            end
            R_SUM: begin
                prod_reg <= P_W'(prod_lo_reg) + (P_W'(prod_hi_reg) << H);
            end
            R_FILL: begin
                if (sat_reg || (prod_reg > P_W'(room_reg))) begin
                    fill_reg <= cap_reg;
                end else begin
                    fill_reg <= lvl_reg + LEVEL_W'(prod_reg);
                end
            end
            R_TAKE: begin
                level_out_reg <= take_level;
                limited_reg   <= take_lim;
                y_reg         <= take_level[LEVEL_W-1:RATE_FRAC_BITS+DIV_PRE];
            end
            R_DIV: begin
                recip_reg <= RP_W'(y_reg) * RP_W'(RECIP);
            end
            default: begin
            end
        endcase
    end

    assign stat.done    = done_reg;
    assign stat.limited = limited_reg;
    assign stat.upd     = mode_reg;
    assign level_out    = level_out_reg;
    assign tokens       = recip_reg[RECIP_SH +: BURST_W];

endmodule

// ----- rtl/keyed_token_bucket_limiter.sv -----
// channel | ports                       | payload                 | accepted when
// input   | s_valid, s_ready, s_item    | ktbl_pkg::in_item_t     | s_valid && s_ready
// result  | m_valid, m_ready, m_item    | ktbl_pkg::out_item_t    | m_valid && m_ready
//
// One item at a time. The lookup travels the row of ENTRIES cells, one cell per cycle:
// an add or an unknown key then goes to the result without the refill unit.
// A check of a stored key adds the refill unit: two partial products of a 22-bit half
// of the elapsed time by the 28-bit rate, and a reciprocal multiply for the quotient.
// aresetn clears the entry count and all control; stored entries are written by adds.
// s_ready rises again once the result sits in the output register; m_ready low holds it.
module keyed_token_bucket_limiter #(
    parameter int ENTRIES        = ktbl_pkg::ENTRIES_DEF,
    parameter int RATE_FRAC_BITS = ktbl_pkg::RATE_FRAC_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ktbl_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output ktbl_pkg::out_item_t m_item
);

    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int LEVEL_W   = ktbl_pkg::BURST_W + ktbl_pkg::MILLION_W + RATE_FRAC_BITS;
    localparam int Q_W       = ktbl_pkg::BURST_W + ktbl_pkg::MILLION_W;
    localparam int OUT_IDX_W = ktbl_pkg::INDEX_W;
    localparam int RATE_W    = ktbl_pkg::RATE_W;
    localparam int BURST_W   = ktbl_pkg::BURST_W;
    localparam int TIME_W    = ktbl_pkg::TIME_W;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b00_0001,
        S_INJECT = 6'b00_0010,
        S_SEARCH = 6'b00_0100,
        S_DECIDE = 6'b00_1000,
        S_REFILL = 6'b01_0000,
        S_RESULT = 6'b10_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    ktbl_pkg::in_item_t   req_reg;
    ktbl_pkg::out_item_t  res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    ktbl_pkg::out_item_t  m_item_reg;
    logic                 out_load;

    logic                 f_hit_reg;
    logic [IDX_W-1:0]     f_idx_reg;
    logic [RATE_W-1:0]    f_rate_reg;
    logic [BURST_W-1:0]   f_burst_reg;
    logic [LEVEL_W-1:0]   f_level_reg;
    logic [TIME_W-1:0]    f_last_reg;

    ktbl_pkg::link_t      lnk      [ENTRIES+1];
    logic [IDX_W-1:0]     ch_idx   [ENTRIES+1];
    logic [RATE_W-1:0]    ch_rate  [ENTRIES+1];
    logic [BURST_W-1:0]   ch_burst [ENTRIES+1];
    logic [LEVEL_W-1:0]   ch_level [ENTRIES+1];
    logic [TIME_W-1:0]    ch_last  [ENTRIES+1];
    logic [ENTRIES-1:0]   occ;

    ktbl_pkg::wr_ctl_t    wr_ctl;
    logic [IDX_W-1:0]     wr_idx;
    logic [LEVEL_W-1:0]   wr_level;
    logic [Q_W-1:0]       init_units;
    logic [LEVEL_W-1:0]   init_level;

    logic                 rf_start;
    ktbl_pkg::rf_stat_t   rf_stat;
    logic [LEVEL_W-1:0]   rf_level;
    logic [BURST_W-1:0]   rf_tokens;

    assign s_ready  = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_RESULT) && (!m_valid_reg || m_ready);

    assign init_units = Q_W'(req_reg.burst_cap) * Q_W'(ktbl_pkg::MILLION);
    assign init_level = LEVEL_W'(init_units) << RATE_FRAC_BITS;

    assign lnk[0].act  = (state_reg == S_INJECT);
    assign lnk[0].hit  = 1'b0;
    assign ch_idx[0]   = '0;
    assign ch_rate[0]  = '0;
    assign ch_burst[0] = '0;
    assign ch_level[0] = '0;
    assign ch_last[0]  = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        assign occ[g] = (count_reg > CNT_W'(g));

        ktbl_cell #(
            .CELL_IDX (g),
            .IDX_W    (IDX_W),
            .LEVEL_W  (LEVEL_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .occupied  (occ[g]),
            .srch_key  (req_reg.key_value),
            .link_in   (lnk[g]),
            .idx_in    (ch_idx[g]),
            .rate_in   (ch_rate[g]),
            .burst_in  (ch_burst[g]),
            .level_in  (ch_level[g]),
            .last_in   (ch_last[g]),
            .link_out  (lnk[g+1]),
            .idx_out   (ch_idx[g+1]),
            .rate_out  (ch_rate[g+1]),
            .burst_out (ch_burst[g+1]),
            .level_out (ch_level[g+1]),
            .last_out  (ch_last[g+1]),
            .wr_ctl    (wr_ctl),
            .wr_idx    (wr_idx),
            .wr_key    (req_reg.key_value),
            .wr_rate   (req_reg.rate_q8),
            .wr_burst  (req_reg.burst_cap),
            .wr_level  (wr_level),
            .wr_last   (req_reg.now_time)
        );
    end

    ktbl_refill #(
        .RATE_FRAC_BITS (RATE_FRAC_BITS),
        .LEVEL_W        (LEVEL_W)
    ) u_refill (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rf_start),
        .rate      (f_rate_reg),
        .burst     (f_burst_reg),
        .level     (f_level_reg),
        .last      (f_last_reg),
        .now       (req_reg.now_time),
        .stat      (rf_stat),
        .level_out (rf_level),
        .tokens    (rf_tokens)
    );

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        res_next   = res_reg;
        wr_ctl     = '0;
        wr_idx     = f_idx_reg;
        wr_level   = rf_level;
        rf_start   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_INJECT;
            end
            S_INJECT: state_next = S_SEARCH;
            S_SEARCH: begin
                if (lnk[ENTRIES].act) state_next = S_DECIDE;
            end
            S_DECIDE: begin
                state_next = S_RESULT;
                res_next   = '{status: ktbl_pkg::ST_OK, entry_index: '0, tokens_left: '0};
                if (req_reg.op == ktbl_pkg::OP_ADD) begin
                    if (req_reg.key_value == '0) begin
                        res_next.status = ktbl_pkg::ST_EMPTY;
                    end else if (count_reg >= CNT_FULL) begin
                        res_next.status = ktbl_pkg::ST_FULL;
                    end else if (f_hit_reg) begin
                        res_next.status = ktbl_pkg::ST_DUP;
                    end else begin
                        wr_ctl.add           = 1'b1;
                        wr_idx               = count_reg[IDX_W-1:0];
                        wr_level             = init_level;
                        count_next           = count_reg + 1'b1;
                        res_next.entry_index = OUT_IDX_W'(count_reg[IDX_W-1:0]);
                        res_next.tokens_left = req_reg.burst_cap;
                    end
                end else if (!f_hit_reg) begin
                    res_next.status = ktbl_pkg::ST_UNKNOWN;
                end else begin
                    rf_start   = 1'b1;
                    state_next = S_REFILL;
                end
            end
            S_REFILL: begin
                if (rf_stat.done) begin
                    wr_ctl.upd           = rf_stat.upd;
                    res_next.status      = rf_stat.limited ? ktbl_pkg::ST_LIMITED
                                                           : ktbl_pkg::ST_OK;
                    res_next.entry_index = OUT_IDX_W'(f_idx_reg);
                    res_next.tokens_left = rf_tokens;
                    state_next           = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_load) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (s_valid && s_ready) begin
            req_reg <= s_item;
        end
        if (state_reg == S_SEARCH) begin
            f_hit_reg   <= lnk[ENTRIES].hit;
            f_idx_reg   <= ch_idx[ENTRIES];
            f_rate_reg  <= ch_rate[ENTRIES];
            f_burst_reg <= ch_burst[ENTRIES];
            f_level_reg <= ch_level[ENTRIES];
            f_last_reg  <= ch_last[ENTRIES];
        end
        if (out_load) begin
            m_item_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("entry count beyond table size");

    a_chain_end: assert property (@(posedge aclk) disable iff (!aresetn)
        lnk[ENTRIES].act |-> (state_reg == S_SEARCH))
        else $error("lookup left the cell row outside the search phase");

    a_add_room: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_ctl.add |-> (count_reg < CNT_FULL) && (req_reg.key_value != '0) && !f_hit_reg)
        else $error("entry stored into a full table or with a bad key");

    a_refill_done: assert property (@(posedge aclk) disable iff (!aresetn)
        rf_stat.done |-> (state_reg == S_REFILL))
        else $error("refill finished without a pending check");

    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg && (state_reg == S_IDLE))
        else $error("result not presented after load");

endmodule
